// ----- rtl/bmw_pkg.sv -----
package bmw_pkg;

    localparam int MAX_DIM  = 64;
    localparam int WIN_R    = 2;
    localparam int SIDE     = 2 * WIN_R + 1;
    localparam int ELEM_W   = SIDE * SIDE;
    localparam int COORD_W  = $clog2(MAX_DIM);
    localparam int DIM_W    = COORD_W + 1;
    localparam int ADDR_W   = 2 * COORD_W;
    localparam int DEPTH    = MAX_DIM * MAX_DIM;
    localparam int IDX_W    = $clog2(SIDE);
    localparam int K_W      = $clog2(ELEM_W);
    localparam int RAD_W    = $clog2(WIN_R + 1);
    localparam int POS_W    = DIM_W + 2;

    localparam logic [1:0] MODE_DIL_FG = 2'd0;
    localparam logic [1:0] MODE_DIL_BG = 2'd1;
    localparam logic [1:0] MODE_ERODE  = 2'd2;

    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_ELEM = 2'd1;
    localparam logic [1:0] CFG_ROWS = 2'd2;
    localparam logic [1:0] CFG_COLS = 2'd3;

    typedef struct packed {
        logic               req_type;
        logic [COORD_W-1:0] pixel_row;
        logic [COORD_W-1:0] pixel_col;
        logic               pixel_in;
    } t_in;

    typedef struct packed {
        logic [COORD_W-1:0] result_row;
        logic [COORD_W-1:0] result_col;
        logic               pixel_out;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    function automatic logic [DIM_W-1:0] f_clamp(input logic [DIM_W-1:0] dim);
        logic [DIM_W-1:0] lim;
        lim = DIM_W'(MAX_DIM);
        return (dim > lim) ? lim : dim;
    endfunction

    // largest Chebyshev offset among the set bits
    function automatic logic [RAD_W-1:0] f_border(input logic [ELEM_W-1:0] elem);
        int a;
        int c;
        int m;
        int b;
        b = 0;
        for (int i = 0; i < SIDE; i++) begin
            for (int j = 0; j < SIDE; j++) begin
                a = (i > WIN_R) ? i - WIN_R : WIN_R - i;
                c = (j > WIN_R) ? j - WIN_R : WIN_R - j;
                m = (a > c) ? a : c;
                if (elem[i * SIDE + j] && m > b) begin
                    b = m;
                end
            end
        end
        return RAD_W'(b);
    endfunction

    function automatic logic f_interior(
        input logic signed [POS_W-1:0] y,
        input logic signed [POS_W-1:0] x,
        input logic [RAD_W-1:0]        b,
        input logic [DIM_W-1:0]        rows,
        input logic [DIM_W-1:0]        cols
    );
        logic signed [POS_W-1:0] sb;
        logic signed [POS_W-1:0] sr;
        logic signed [POS_W-1:0] sc;
        sb = $signed({{(POS_W-RAD_W){1'b0}}, b});
        sr = $signed({2'b00, rows});
        sc = $signed({2'b00, cols});
        return (y >= sb) && (y < sr - sb) && (x >= sb) && (x < sc - sb);
    endfunction

endpackage

// ----- rtl/bmw_ram.sv -----
module bmw_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/binary_morphology_window_top.sv -----
// Write transfer: taken whenever the block is idle.
// Read transfer: the 25 element offsets are read from the single-port image
// memory one per cycle; after the scan drains, the result is loaded into the
// output register once it is free, and only then is a new request taken.
// Reset (synchronous, active low) clears control and the configuration
// registers; the image memory is not cleared.
module binary_morphology_window_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  bmw_pkg::t_in                      i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output bmw_pkg::t_out                     o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [1:0]                        i_cfg_index,
    input  logic [bmw_pkg::ELEM_W-1:0]        i_cfg_data
);

    bmw_pkg::t_state r_state, n_state;

    logic [1:0]                   r_mode;
    logic [bmw_pkg::ELEM_W-1:0]   r_elem;
    logic [bmw_pkg::DIM_W-1:0]    r_rows;
    logic [bmw_pkg::DIM_W-1:0]    r_cols;

    logic [bmw_pkg::COORD_W-1:0]  r_row, n_row;
    logic [bmw_pkg::COORD_W-1:0]  r_col, n_col;
    logic [bmw_pkg::IDX_W-1:0]    r_dr, n_dr;
    logic [bmw_pkg::IDX_W-1:0]    r_dc, n_dc;
    logic                         r_pend, n_pend;
    logic                         r_hit, n_hit;
    logic                         r_out_valid, n_out_valid;
    bmw_pkg::t_out                r_out, n_out;

    logic [bmw_pkg::DIM_W-1:0]    w_rows;
    logic [bmw_pkg::DIM_W-1:0]    w_cols;
    logic [bmw_pkg::RAD_W-1:0]    w_b;
    logic [bmw_pkg::K_W-1:0]      w_k;
    logic signed [bmw_pkg::POS_W-1:0] w_y;
    logic signed [bmw_pkg::POS_W-1:0] w_x;
    logic signed [bmw_pkg::POS_W-1:0] w_ry;
    logic signed [bmw_pkg::POS_W-1:0] w_rx;
    logic                         w_issue;
    logic                         w_in_acc;
    logic                         w_inside;
    logic                         w_we;
    logic [bmw_pkg::ADDR_W-1:0]   w_addr;
    logic                         w_rdata;
    logic                         w_want;
    logic                         w_pix;

    assign w_rows   = bmw_pkg::f_clamp(r_rows);
    assign w_cols   = bmw_pkg::f_clamp(r_cols);
    assign w_b      = bmw_pkg::f_border(r_elem);
    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_want   = (r_mode == bmw_pkg::MODE_DIL_FG);

    assign o_in_ready  = (r_state == bmw_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= bmw_pkg::MODE_DIL_FG;
            r_elem <= '0;
            r_rows <= bmw_pkg::DIM_W'(bmw_pkg::MAX_DIM);
            r_cols <= bmw_pkg::DIM_W'(bmw_pkg::MAX_DIM);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bmw_pkg::CFG_MODE: r_mode <= i_cfg_data[1:0];
                bmw_pkg::CFG_ELEM: r_elem <= i_cfg_data;
                bmw_pkg::CFG_ROWS: r_rows <= i_cfg_data[bmw_pkg::DIM_W-1:0];
                bmw_pkg::CFG_COLS: r_cols <= i_cfg_data[bmw_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // centre positions for the current offset: scatter modes look back, erosion forward
    assign w_k  = bmw_pkg::K_W'(r_dr * bmw_pkg::SIDE) + bmw_pkg::K_W'(r_dc);
    assign w_ry = $signed({3'b000, r_row});
    assign w_rx = $signed({3'b000, r_col});
    always_comb begin
        if (r_mode == bmw_pkg::MODE_ERODE) begin
            w_y = w_ry + $signed({3'b000, r_dr}) - bmw_pkg::POS_W'(bmw_pkg::WIN_R);
            w_x = w_rx + $signed({3'b000, r_dc}) - bmw_pkg::POS_W'(bmw_pkg::WIN_R);
            w_issue = r_elem[w_k];
        end else begin
            w_y = w_ry - $signed({3'b000, r_dr}) + bmw_pkg::POS_W'(bmw_pkg::WIN_R);
            w_x = w_rx - $signed({3'b000, r_dc}) + bmw_pkg::POS_W'(bmw_pkg::WIN_R);
            w_issue = r_elem[w_k] && bmw_pkg::f_interior(w_y, w_x, w_b, w_rows, w_cols);
        end
    end

    assign w_we = w_in_acc && !i_in.req_type
               && ({1'b0, i_in.pixel_row} < w_rows)
               && ({1'b0, i_in.pixel_col} < w_cols);
    assign w_addr = (r_state == bmw_pkg::S_IDLE)
                  ? {i_in.pixel_row, i_in.pixel_col}
                  : {w_y[bmw_pkg::COORD_W-1:0], w_x[bmw_pkg::COORD_W-1:0]};

    bmw_ram #(
        .WIDTH (1),
        .DEPTH (bmw_pkg::DEPTH)
    ) u_image (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (i_in.pixel_in),
        .o_rdata (w_rdata)
    );

    assign w_inside = ({1'b0, r_row} < w_rows) && ({1'b0, r_col} < w_cols);

    always_comb begin
        case (r_mode)
            bmw_pkg::MODE_DIL_FG: w_pix = w_inside && r_hit;
            bmw_pkg::MODE_DIL_BG: w_pix = w_inside && !r_hit;
            bmw_pkg::MODE_ERODE:  w_pix = w_inside && !r_hit
                && bmw_pkg::f_interior(w_ry, w_rx, w_b, w_rows, w_cols);
            default:              w_pix = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bmw_pkg::S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_col <= n_col;
        r_dr  <= n_dr;
        r_dc  <= n_dc;
        r_hit <= n_hit;
        r_out <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_dr        = r_dr;
        n_dc        = r_dc;
        n_pend      = 1'b0;
        n_hit       = r_hit || (r_pend && (w_rdata == w_want));
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            bmw_pkg::S_IDLE: begin
                if (w_in_acc && i_in.req_type) begin
                    n_row   = i_in.pixel_row;
                    n_col   = i_in.pixel_col;
                    n_dr    = '0;
                    n_dc    = '0;
                    n_hit   = 1'b0;
                    n_state = bmw_pkg::S_SCAN;
                end
            end
            bmw_pkg::S_SCAN: begin
                n_pend = w_issue;
                if (r_dc == bmw_pkg::IDX_W'(bmw_pkg::SIDE - 1)) begin
                    n_dc = '0;
                    if (r_dr == bmw_pkg::IDX_W'(bmw_pkg::SIDE - 1)) begin
                        n_state = bmw_pkg::S_DRAIN;
                    end else begin
                        n_dr = r_dr + 1'b1;
                    end
                end else begin
                    n_dc = r_dc + 1'b1;
                end
            end
            bmw_pkg::S_DRAIN: begin
                n_state = bmw_pkg::S_DONE;
            end
            bmw_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.result_row = r_row;
                    n_out.result_col = r_col;
                    n_out.pixel_out  = w_pix;
                    n_out_valid      = 1'b1;
                    n_state          = bmw_pkg::S_IDLE;
                end
            end
            default: n_state = bmw_pkg::S_IDLE;
        endcase
    end

    a_pend_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(r_state == bmw_pkg::S_SCAN))
        else $error("memory read pending outside a window scan");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == bmw_pkg::S_IDLE))
        else $error("image write during a read");

    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bmw_pkg::S_SCAN && r_dr == bmw_pkg::IDX_W'(bmw_pkg::SIDE - 1)
            && r_dc == bmw_pkg::IDX_W'(bmw_pkg::SIDE - 1))
        |=> (r_state == bmw_pkg::S_DRAIN))
        else $error("window scan did not end after the last offset");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == bmw_pkg::S_DONE))
        else $error("result transfer raised without a finished read");

endmodule
